// ----- rtl/atr_pkg.sv -----
// ----------------------------------------------------------------------------
// atr_pkg
// Shared constants, types and helpers for the accelerometer tilt pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package atr_pkg;

    // Requested CORDIC iteration count and the table-bounded count that runs.
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_SIZE    = 24;
    localparam int STG = (CORDIC_STAGES < TABLE_SIZE) ? CORDIC_STAGES : TABLE_SIZE;

    localparam int SQRT_STEPS = 32;   // one result bit per step
    localparam int VW         = 35;   // CORDIC vector width, signed
    localparam int AW         = 32;   // angle accumulator width, signed

    // 90 degrees in 2^-16 hundredths
    localparam logic signed [AW-1:0] QUARTER_TURN = 32'sd589824000;
    localparam logic signed [16:0]   ROLL_LIMIT   = 17'sd18000;
    localparam logic signed [16:0]   PITCH_LIMIT  = 17'sd9000;

    localparam logic [AW-1:0] ATAN_TABLE [0:TABLE_SIZE-1] = '{
        32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
        32'd23437865,  32'd11730358,  32'd5866610,  32'd2933484,
        32'd1466764,   32'd733385,    32'd366693,   32'd183346,
        32'd91673,     32'd45837,     32'd22918,    32'd11459,
        32'd5730,      32'd2865,      32'd1432,     32'd716,
        32'd358,       32'd179,       32'd90,       32'd45
    };

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_axes;

    // Round 2^-16 hundredths to whole hundredths, ties away from zero.
    function automatic logic signed [16:0] round_ang(input logic signed [AW-1:0] ang);
        logic [AW:0]   mag;
        logic [AW:0]   sum;
        logic [15:0]   q;
        mag = ang[AW-1] ? -{ang[AW-1], ang} : {ang[AW-1], ang};
        sum = mag + 33'd32768;
        q   = sum[31:16];
        return ang[AW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic signed [16:0] clamp(input logic signed [16:0] v,
                                                 input logic signed [16:0] lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/atr_if.sv -----
// ----------------------------------------------------------------------------
// atr_if
// Valid/ready channels: raw axis sample in, tilt angles out.
// ----------------------------------------------------------------------------
`default_nettype none

interface atr_axes_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atr_tilt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    modport source (output valid, roll, pitch, input ready);
    modport sink   (input valid, roll, pitch, output ready);
endinterface

`default_nettype wire

// ----- rtl/accel_tilt_roll_pitch_top.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_top
// Roll = atan2(y, z) and pitch = -atan2(x, hypot(y, z)) in hundredths of a
// degree from one raw three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Pipeline: squares, their sum, the bit-per-stage square root, a pre-rotation,
//   the CORDIC iterations, then round/clamp into the output register.
// Throughput: one request per cycle; the whole pipeline advances together
//   and halts only while the output register holds an untaken result.
// Reset: synchronous, active low; clears the valid bits only.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_roll_pitch_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    atr_axes_if.sink   i_accel,
    atr_tilt_if.source o_tilt
);

    // Global advance: every stage moves when the output slot is free or drains.
    logic n_ce;
    assign n_ce          = !o_tilt.valid || o_tilt.ready;
    assign i_accel.ready = n_ce;

    atr_pkg::t_axes n_in;
    assign n_in = '{x: i_accel.accel_x, y: i_accel.accel_y, z: i_accel.accel_z};

    // Stage 1: squares of y and z (16x16 each)
    logic           r_v1;
    logic [31:0]    r_yy, r_zz;
    atr_pkg::t_axes r_s1;

    // Stage 2: y^2 + z^2 (fits 32 bits unsigned, max 2^31)
    logic           r_v2;
    logic [31:0]    r_sq;
    atr_pkg::t_axes r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (n_ce) begin
            r_v1 <= i_accel.valid;
            r_v2 <= r_v1;
        end
        if (n_ce) begin
            r_yy <= 32'(i_accel.accel_y * i_accel.accel_y);
            r_zz <= 32'(i_accel.accel_z * i_accel.accel_z);
            r_s1 <= n_in;
            r_sq <= r_yy + r_zz;
            r_s2 <= r_s1;
        end
    end

    // Magnitude of (y, z) with 16 fraction bits
    logic           w_v3;
    logic [31:0]    w_hyp;
    atr_pkg::t_axes w_s3;

    atr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (n_ce),
        .i_vld   (r_v2),
        .i_sq    (r_sq),
        .i_side  (r_s2),
        .o_vld   (w_v3),
        .o_root  (w_hyp),
        .o_side  (w_s3)
    );

    // Both arctangents run side by side; the last stage is the output register.
    atr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (n_ce),
        .i_vld   (w_v3),
        .i_hyp   (w_hyp),
        .i_side  (w_s3),
        .o_vld   (o_tilt.valid),
        .o_roll  (o_tilt.roll),
        .o_pitch (o_tilt.pitch)
    );

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tilt.valid |-> (o_tilt.roll <= 16'sd18000) && (o_tilt.roll >= -16'sd18000))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tilt.valid |-> (o_tilt.pitch <= 15'sd9000) && (o_tilt.pitch >= -15'sd9000))
        else $error("pitch out of range");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accel.ready == (!o_tilt.valid || o_tilt.ready))
        else $error("input ready does not follow output slot");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accel.ready |=> $stable(r_sq) && $stable(r_v2))
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ----- rtl/atr_isqrt.sv -----
// ----------------------------------------------------------------------------
// atr_isqrt
// Pipelined integer square root of (sq << 32), one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module atr_isqrt (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ce,
    input  wire logic          i_vld,
    input  wire logic [31:0]   i_sq,
    input  atr_pkg::t_axes     i_side,
    output logic               o_vld,
    output logic [31:0]        o_root,
    output atr_pkg::t_axes     o_side
);

    localparam int N = atr_pkg::SQRT_STEPS;

    logic           r_vld  [0:N];
    logic [63:0]    r_num  [0:N];
    logic [63:0]    r_res  [0:N];
    atr_pkg::t_axes r_side [0:N];

    assign r_vld[0]  = i_vld;
    assign r_num[0]  = {i_sq, 32'd0};
    assign r_res[0]  = 64'd0;
    assign r_side[0] = i_side;

    for (genvar g = 0; g < N; g++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic [63:0] n_trial;
        assign n_trial = r_res[g] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_ce) begin
                r_side[g+1] <= r_side[g];
                if (r_num[g] >= n_trial) begin
                    r_num[g+1] <= r_num[g] - n_trial;
                    r_res[g+1] <= (r_res[g] >> 1) + BIT;
                end else begin
                    r_num[g+1] <= r_num[g];
                    r_res[g+1] <= r_res[g] >> 1;
                end
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_root = r_res[N][31:0];
    assign o_side = r_side[N];

endmodule

`default_nettype wire

// ----- rtl/atr_cordic.sv -----
// ----------------------------------------------------------------------------
// atr_cordic
// Two-lane CORDIC vectoring pipeline (roll, pitch) with round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module atr_cordic (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_ce,
    input  wire logic          i_vld,
    input  wire logic [31:0]   i_hyp,
    input  atr_pkg::t_axes     i_side,
    output logic               o_vld,
    output logic signed [15:0] o_roll,
    output logic signed [14:0] o_pitch
);

    localparam int N  = atr_pkg::STG;
    localparam int VW = atr_pkg::VW;
    localparam int AW = atr_pkg::AW;

    logic                 r_vld [0:N];
    logic signed [VW-1:0] r_ra  [0:N];
    logic signed [VW-1:0] r_rb  [0:N];
    logic signed [AW-1:0] r_rang[0:N];
    logic                 r_rz  [0:N];
    logic signed [VW-1:0] r_pa  [0:N];
    logic signed [VW-1:0] r_pb  [0:N];
    logic signed [AW-1:0] r_pang[0:N];
    logic                 r_pz  [0:N];

    logic signed [VW-1:0] n_za, n_yb, n_xb;
    assign n_za = {{3{i_side.z[15]}}, i_side.z, 16'd0};
    assign n_yb = {{3{i_side.y[15]}}, i_side.y, 16'd0};
    assign n_xb = {{3{i_side.x[15]}}, i_side.x, 16'd0};

    // pre-rotation into the right half plane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_vld;
        end
        if (i_ce) begin
            r_rz[0] <= (i_side.y == 16'sd0) && (i_side.z == 16'sd0);
            r_pz[0] <= (i_side.x == 16'sd0) && (i_hyp == 32'd0);
            if (n_za < 0) begin
                if (n_yb >= 0) begin
                    r_ra[0]   <= n_yb;
                    r_rb[0]   <= -n_za;
                    r_rang[0] <= atr_pkg::QUARTER_TURN;
                end else begin
                    r_ra[0]   <= -n_yb;
                    r_rb[0]   <= n_za;
                    r_rang[0] <= -atr_pkg::QUARTER_TURN;
                end
            end else begin
                r_ra[0]   <= n_za;
                r_rb[0]   <= n_yb;
                r_rang[0] <= '0;
            end
            r_pa[0]   <= $signed({3'd0, i_hyp});
            r_pb[0]   <= n_xb;
            r_pang[0] <= '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_iter
        localparam logic signed [AW-1:0] T = $signed(atr_pkg::ATAN_TABLE[g]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_ce) begin
                r_vld[g+1] <= r_vld[g];
            end
            if (i_ce) begin
                r_rz[g+1] <= r_rz[g];
                r_pz[g+1] <= r_pz[g];
                if (!r_rb[g][VW-1]) begin
                    r_ra[g+1]   <= r_ra[g] + (r_rb[g] >>> g);
                    r_rb[g+1]   <= r_rb[g] - (r_ra[g] >>> g);
                    r_rang[g+1] <= r_rang[g] + T;
                end else begin
                    r_ra[g+1]   <= r_ra[g] - (r_rb[g] >>> g);
                    r_rb[g+1]   <= r_rb[g] + (r_ra[g] >>> g);
                    r_rang[g+1] <= r_rang[g] - T;
                end
                if (!r_pb[g][VW-1]) begin
                    r_pa[g+1]   <= r_pa[g] + (r_pb[g] >>> g);
                    r_pb[g+1]   <= r_pb[g] - (r_pa[g] >>> g);
                    r_pang[g+1] <= r_pang[g] + T;
                end else begin
                    r_pa[g+1]   <= r_pa[g] - (r_pb[g] >>> g);
                    r_pb[g+1]   <= r_pb[g] + (r_pa[g] >>> g);
                    r_pang[g+1] <= r_pang[g] - T;
                end
            end
        end
    end

    // round, negate pitch, clamp
    logic signed [16:0] n_roll, n_pitch;
    assign n_roll  = atr_pkg::clamp(atr_pkg::round_ang(r_rang[N]), atr_pkg::ROLL_LIMIT);
    assign n_pitch = atr_pkg::clamp(-atr_pkg::round_ang(r_pang[N]), atr_pkg::PITCH_LIMIT);

    logic               r_ovld;
    logic signed [15:0] r_roll;
    logic signed [14:0] r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_ce) begin
            r_ovld <= r_vld[N];
        end
        if (i_ce) begin
            r_roll  <= r_rz[N] ? 16'sd0 : n_roll[15:0];
            r_pitch <= r_pz[N] ? 15'sd0 : n_pitch[14:0];
        end
    end

    assign o_vld   = r_ovld;
    assign o_roll  = r_roll;
    assign o_pitch = r_pitch;

endmodule

`default_nettype wire

// ----- tb/accel_tilt_roll_pitch_top_tb.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch_top_tb
// Self-checking bench for the tilt pipeline: directed corner samples, then
// random samples, with bursty requests, output stalls and a long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module accel_tilt_roll_pitch_top_tb;

    localparam int  N_RANDOM   = 760;
    localparam int  LATENCY    = 36 + atr_pkg::STG;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  LONG_HOLD  = 200;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } t_tilt;

    logic i_clk;
    logic i_rst_n;

    atr_axes_if accel_ch ();
    atr_tilt_if tilt_ch ();

    accel_tilt_roll_pitch_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accel (accel_ch.sink),
        .o_tilt  (tilt_ch.source)
    );

    atr_pkg::t_axes sample_q [$];   // requests waiting to be driven
    t_tilt tilt_q   [$];       // predicted angles, oldest first
    int    errors;
    int    n_sent;
    int    n_checked;
    int    cycles;
    bit    stim_done;
    bit    hold_req;           // asks the receiver for a long hold-off
    bit    pause_req;          // sender waits for the pipeline to drain

    // ------------------------------------------------------------------------
    // Predictor: CORDIC vectoring atan2 at wide integer precision, exact
    // square root for the magnitude, rounding ties away from zero, clamp.
    // ------------------------------------------------------------------------
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint vector_angle(longint b, longint a);
        longint ang;
        longint t;
        longint na;
        longint nb;
        longint m;
        ang = 0;
        if (a == 0 && b == 0) return 0;
        if (a < 0) begin
            t = a;
            if (b >= 0) begin
                a = b; b = -t; ang = atr_pkg::QUARTER_TURN;
            end else begin
                a = -b; b = t; ang = -longint'(atr_pkg::QUARTER_TURN);
            end
        end
        for (int i = 0; i < atr_pkg::STG; i++) begin
            if (b >= 0) begin
                na = a + shr_floor(b, i);
                nb = b - shr_floor(a, i);
                ang += longint'(atr_pkg::ATAN_TABLE[i]);
            end else begin
                na = a - shr_floor(b, i);
                nb = b + shr_floor(a, i);
                ang -= longint'(atr_pkg::ATAN_TABLE[i]);
            end
            a = na;
            b = nb;
        end
        m = ((ang < 0 ? -ang : ang) + 32768) >>> 16;
        return (ang < 0) ? -m : m;
    endfunction

    function automatic longint int_sqrt(logic [63:0] num);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > num) bitv >>= 2;
        while (bitv != 0) begin
            if (num >= res + bitv) begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint limit_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_tilt predict_tilt(atr_pkg::t_axes s);
        longint x, y, z, hyp;
        logic [63:0] sq;
        t_tilt r;
        x   = s.x;
        y   = s.y;
        z   = s.z;
        sq  = 64'(y * y + z * z);
        hyp = int_sqrt(sq << 32);
        r.roll  = 16'(limit_to(vector_angle(y * 65536, z * 65536), 18000));
        r.pitch = 15'(limit_to(-vector_angle(x * 65536, hyp), 9000));
        return r;
    endfunction

    task automatic add_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        atr_pkg::t_axes s;
        s.x = x;
        s.y = y;
        s.z = z;
        sample_q.push_back(s);
    endtask

    function automatic logic [15:0] rand_axis();
        // mostly full range, some near zero and some at the rails
        case ($urandom_range(0, 9))
            0:       return 16'($signed($urandom_range(0, 8)) - 4);
            1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            2:       return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and the cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout with %0d results outstanding", $time, tilt_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of requests separated by random gaps
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    initial begin
        accel_ch.valid   = 1'b0;
        accel_ch.accel_x = '0;
        accel_ch.accel_y = '0;
        accel_ch.accel_z = '0;
        tilt_ch.ready    = 1'b0;
        burst_left = 0;
        gap_left   = 0;
        errors     = 0;
        n_sent     = 0;
        n_checked  = 0;
        cycles     = 0;
        hold_req   = 1'b0;
        pause_req  = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            accel_ch.valid <= 1'b0;
        end else begin
            automatic bit fire = accel_ch.valid && accel_ch.ready;
            automatic bit busy = accel_ch.valid && !fire;
            if (fire) begin
                tilt_q.push_back(predict_tilt({accel_ch.accel_x, accel_ch.accel_y,
                                               accel_ch.accel_z}));
                n_sent <= n_sent + 1;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    accel_ch.valid <= 1'b0;
                end else if (pause_req && (tilt_q.size() != 0 || fire)) begin
                    accel_ch.valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    automatic atr_pkg::t_axes s = sample_q.pop_front();
                    accel_ch.valid   <= 1'b1;
                    accel_ch.accel_x <= s.x;
                    accel_ch.accel_y <= s.y;
                    accel_ch.accel_z <= s.z;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    accel_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls on its own pattern, with stall-free and long hold-off
    // stretches; checks every response against the oldest prediction.
    // ------------------------------------------------------------------------
    int phase_cnt;
    int hold_cnt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tilt_ch.ready <= 1'b0;
            phase_cnt     <= 0;
            hold_cnt      <= 0;
        end else begin
            if (tilt_ch.valid && tilt_ch.ready) begin
                if (tilt_q.size() == 0) begin
                    $display("%0t: unexpected response roll=%0d pitch=%0d", $time,
                             tilt_ch.roll, tilt_ch.pitch);
                    errors++;
                end else begin
                    automatic t_tilt e = tilt_q.pop_front();
                    if (tilt_ch.roll !== e.roll) begin
                        $display("%0t: roll expected %0d actual %0d", $time,
                                 e.roll, tilt_ch.roll);
                        errors++;
                    end
                    if (tilt_ch.pitch !== e.pitch) begin
                        $display("%0t: pitch expected %0d actual %0d", $time,
                                 e.pitch, tilt_ch.pitch);
                        errors++;
                    end
                    n_checked <= n_checked + 1;
                end
            end
            phase_cnt <= phase_cnt + 1;
            if (hold_cnt > 0) begin
                hold_cnt      <= hold_cnt - 1;
                tilt_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req      <= 1'b0;
                hold_cnt      <= LONG_HOLD;
                tilt_ch.ready <= 1'b0;
            end else if (phase_cnt[9:8] == 2'b01) begin
                tilt_ch.ready <= 1'b1;          // stall-free stretch
            end else begin
                tilt_ch.ready <= ($urandom_range(0, 3) != 0) && (phase_cnt[2:0] != 3'd5);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequencing and end of run
    // ------------------------------------------------------------------------
    initial begin
        stim_done = 1'b0;
        @(posedge i_rst_n);

        // Directed: zero vector, axis rails, all quadrants, the -180/+180
        // seam of roll, pitch at +-90 and mixed extremes.
        add_sample(16'h0000, 16'h0000, 16'h0000);
        add_sample(16'h0005, 16'h0000, 16'h0000);
        add_sample(16'h8000, 16'h0000, 16'h0000);
        add_sample(16'h7FFF, 16'h0000, 16'h0000);
        add_sample(16'h0000, 16'h7FFF, 16'h0000);
        add_sample(16'h0000, 16'h8000, 16'h0000);
        add_sample(16'h0000, 16'h0000, 16'h7FFF);
        add_sample(16'h0000, 16'h0000, 16'h8000);
        add_sample(16'h0000, 16'h0000, 16'hFFFF);
        add_sample(16'h0000, 16'h0001, 16'h8000);
        add_sample(16'h0000, 16'hFFFF, 16'h8000);
        add_sample(16'h8000, 16'h8000, 16'h8000);
        add_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        add_sample(16'h8000, 16'h7FFF, 16'h8000);
        add_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        add_sample(16'h0001, 16'h0001, 16'h0001);
        add_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_sample(16'h1000, 16'hF000, 16'h1000);
        add_sample(16'hAAAA, 16'h5555, 16'hAAAA);
        add_sample(16'h5555, 16'hAAAA, 16'h5555);
        wait (sample_q.size() == 0);

        // Random samples; the long output hold-off lands during a dense burst.
        for (int i = 0; i < N_RANDOM; i++) begin
            add_sample(rand_axis(), rand_axis(), rand_axis());
            if (i == 300) begin
                wait (sample_q.size() == 0);
                @(posedge i_clk);
                hold_req = 1'b1;
                for (int k = 0; k < 120; k++) add_sample(16'($urandom), 16'($urandom),
                                                         16'($urandom));
            end
            if (i == 600) begin
                wait (sample_q.size() == 0);
                pause_req = 1'b1;
                wait (tilt_q.size() == 0 && !accel_ch.valid);
                pause_req = 1'b0;
            end
        end
        wait (sample_q.size() == 0 && !accel_ch.valid);
        stim_done = 1'b1;
        wait (tilt_q.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("Sent %0d samples, checked %0d roll/pitch responses (directed corners,",
                 n_sent, n_checked);
        $display("random axes, bursty input, output stalls and a long hold-off).");
        if (errors == 0 && tilt_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
